FILE: hw/rtl/tnwc_pkg.sv
package tnwc_pkg;

    localparam int PS_W           = 32;
    localparam int PRD_W          = 2 * PS_W;
    localparam int CX_W           = 65;
    localparam int MANT_W         = 30;
    localparam int SQ_STEPS       = 32;
    localparam int WD_W           = 64;
    localparam int UNIT_FIXED_LAT = 39;

    typedef logic signed [CX_W-1:0] t_cx;
    typedef logic [WD_W-1:0]        t_wide;

endpackage

FILE: hw/rtl/tnwc_unit.sv
module tnwc_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  tnwc_pkg::t_cx              i_a [3],
    output logic signed [FRAC_BITS+1:0] o_u [3],
    output logic                       o_zero
);
    import tnwc_pkg::*;

    localparam int BL_W = $clog2(CX_W + 1);
    localparam int DN   = FRAC_BITS + 1;
    localparam int U_W  = FRAC_BITS + 2;

    logic [CX_W-1:0]     n0_m [3];
    logic [CX_W-1:0]     r0_m [3];
    logic [2:0]          r0_neg;
    logic [CX_W-1:0]     r0_or;
    logic [BL_W-1:0]     n1_bl;
    logic [BL_W-1:0]     r1_bl;
    logic [CX_W-1:0]     r1_m [3];
    logic [2:0]          r1_neg;
    logic                r1_zero;
    logic [MANT_W-1:0]   n2_m [3];
    logic [MANT_W-1:0]   r2_m [3];
    logic [2:0]          r2_neg;
    logic                r2_zero;
    logic [2*MANT_W-1:0] r3_sq [3];
    logic [MANT_W-1:0]   r3_m [3];
    logic [2:0]          r3_neg;
    logic                r3_zero;

    t_wide               r_sx [0:SQ_STEPS];
    t_wide               r_sr [0:SQ_STEPS];
    logic [MANT_W-1:0]   r_sm [0:SQ_STEPS][3];
    logic [2:0]          r_sneg [0:SQ_STEPS];
    logic                r_szero [0:SQ_STEPS];

    t_wide               r_drem [1:DN][3];
    t_wide               r_dlen [1:DN];
    logic [DN-1:0]       r_dq [1:DN][3];
    logic [2:0]          r_dneg [1:DN];
    logic                r_dzero [1:DN];

    logic signed [U_W-1:0] n_u [3];
    logic signed [U_W-1:0] r_u [3];
    logic                  r_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n0_m[i] = i_a[i][CX_W-1] ? $unsigned(-i_a[i]) : $unsigned(i_a[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_m   <= n0_m;
            r0_neg <= {i_a[2][CX_W-1], i_a[1][CX_W-1], i_a[0][CX_W-1]};
            r0_or  <= n0_m[0] | n0_m[1] | n0_m[2];
        end
    end

    always_comb begin
        n1_bl = '0;
        for (int k = 0; k < CX_W; k++) begin
            if (r0_or[k]) begin
                n1_bl = BL_W'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bl   <= n1_bl;
            r1_m    <= r0_m;
            r1_neg  <= r0_neg;
            r1_zero <= (r0_or == '0);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r1_bl > BL_W'(MANT_W)) begin
                n2_m[i] = MANT_W'(r1_m[i] >> (r1_bl - BL_W'(MANT_W)));
            end else begin
                n2_m[i] = MANT_W'(r1_m[i] << (BL_W'(MANT_W) - r1_bl));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m    <= n2_m;
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= (2*MANT_W)'(r2_m[i]) * (2*MANT_W)'(r2_m[i]);
            end
            r3_m       <= r2_m;
            r3_neg     <= r2_neg;
            r3_zero    <= r2_zero;
            r_sx[0]    <= WD_W'(r3_sq[0]) + WD_W'(r3_sq[1]) + WD_W'(r3_sq[2]);
            r_sr[0]    <= '0;
            r_sm[0]    <= r3_m;
            r_sneg[0]  <= r3_neg;
            r_szero[0] <= r3_zero;
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam t_wide STEP_BIT = t_wide'(1) << (2 * (SQ_STEPS - 1 - j));
        t_wide w_trial;

        assign w_trial = r_sr[j] + STEP_BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sx[j] >= w_trial) begin
                    r_sx[j+1] <= r_sx[j] - w_trial;
                    r_sr[j+1] <= (r_sr[j] >> 1) + STEP_BIT;
                end else begin
                    r_sx[j+1] <= r_sx[j];
                    r_sr[j+1] <= r_sr[j] >> 1;
                end
                r_sm[j+1]    <= r_sm[j];
                r_sneg[j+1]  <= r_sneg[j];
                r_szero[j+1] <= r_szero[j];
            end
        end
    end

    for (genvar i = 0; i < DN; i++) begin : g_div
        localparam int KB = FRAC_BITS - i;
        t_wide         w_rem [3];
        t_wide         w_len;
        t_wide         w_div;
        logic [DN-1:0] w_q [3];
        logic [2:0]    w_neg;
        logic          w_zero;

        if (i == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    w_rem[l] = WD_W'(r_sm[SQ_STEPS][l]) << FRAC_BITS;
                    w_q[l]   = '0;
                end
                w_len  = r_sr[SQ_STEPS];
                w_neg  = r_sneg[SQ_STEPS];
                w_zero = r_szero[SQ_STEPS];
            end
        end else begin : g_next
            always_comb begin
                w_rem  = r_drem[i];
                w_q    = r_dq[i];
                w_len  = r_dlen[i];
                w_neg  = r_dneg[i];
                w_zero = r_dzero[i];
            end
        end

        assign w_div = w_len << KB;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (w_rem[l] >= w_div) begin
                        r_drem[i+1][l] <= w_rem[l] - w_div;
                        r_dq[i+1][l]   <= w_q[l] | (DN'(1) << KB);
                    end else begin
                        r_drem[i+1][l] <= w_rem[l];
                        r_dq[i+1][l]   <= w_q[l];
                    end
                end
                r_dlen[i+1]  <= w_len;
                r_dneg[i+1]  <= w_neg;
                r_dzero[i+1] <= w_zero;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_dzero[DN]) begin
                n_u[l] = '0;
            end else if (r_dneg[DN][l]) begin
                n_u[l] = -$signed({1'b0, r_dq[DN][l]});
            end else begin
                n_u[l] = $signed({1'b0, r_dq[DN][l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= n_u;
            r_zero <= r_dzero[DN];
        end
    end

    assign o_u    = r_u;
    assign o_zero = r_zero;

endmodule

FILE: hw/rtl/tnw_to_cartesian_vector_transform_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    thrust t/n/w, position, velocity
// output    out        o_out_valid / i_out_stall  thrust x/y/z, degenerate
//
// One transaction is accepted every cycle unless a result is stalled at the output;
// each result passes through three unit-vector pipelines, two in parallel and then a
// third (square root one bit per stage, division one quotient bit per stage).
// Reset is synchronous and clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline, so the input stalls in the same cycle.
module tnw_to_cartesian_vector_transform_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_thrust_tangential,
    input  logic signed [DATA_WIDTH-1:0] i_thrust_normal,
    input  logic signed [DATA_WIDTH-1:0] i_thrust_crosstrack,
    input  logic signed [DATA_WIDTH-1:0] i_position_x,
    input  logic signed [DATA_WIDTH-1:0] i_position_y,
    input  logic signed [DATA_WIDTH-1:0] i_position_z,
    input  logic signed [DATA_WIDTH-1:0] i_velocity_x,
    input  logic signed [DATA_WIDTH-1:0] i_velocity_y,
    input  logic signed [DATA_WIDTH-1:0] i_velocity_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_thrust_x,
    output logic signed [DATA_WIDTH-1:0] o_thrust_y,
    output logic signed [DATA_WIDTH-1:0] o_thrust_z,
    output logic                         o_degenerate
);
    import tnwc_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int U_W  = FRAC_BITS + 2;
    localparam int P_W  = U_W + DW;
    localparam int A_W  = P_W + 2;
    localparam int UL   = UNIT_FIXED_LAT + FRAC_BITS;
    localparam int ST_U = 3 + UL;
    localparam int ST_N = ST_U + 2 + UL;
    localparam int ST_H = ST_N + 2;
    localparam int LAST = ST_H + 1;

    localparam logic signed [A_W:0] RND     = (A_W+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [A_W:0] SAT_MAX = {{(A_W+2-DW){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [A_W:0] SAT_MIN = ~SAT_MAX;

    logic                  w_adv;
    logic                  r_vld [0:LAST];

    logic signed [DW-1:0]  r_thr [0:ST_N][3];
    logic signed [DW-1:0]  r_a_r [3];
    logic signed [DW-1:0]  r_a_v [3];
    logic signed [PS_W-1:0] n_b_r [3];
    logic signed [PS_W-1:0] n_b_v [3];
    logic signed [PS_W-1:0] r_b_r [3];
    logic signed [PS_W-1:0] r_b_v [3];
    logic signed [PRD_W-1:0] r_c_p [6];
    logic signed [PS_W-1:0] r_c_v [3];
    t_cx                   r_d_c [3];
    t_cx                   r_d_v [3];

    logic signed [U_W-1:0] w_w [3];
    logic signed [U_W-1:0] w_t [3];
    logic signed [U_W-1:0] w_n [3];
    logic                  w_wzero;

    logic signed [U_W-1:0] r_dt [ST_U+1:ST_N][3];
    logic signed [U_W-1:0] r_dw [ST_U+1:ST_N][3];
    logic                  r_dg [ST_U+1:ST_H];
    logic signed [2*U_W-1:0] r_e_p [6];
    t_cx                   r_f_n [3];

    logic signed [P_W-1:0] r_g_p [3][3];
    logic signed [A_W-1:0] r_h_acc [3];
    logic signed [A_W:0]   n_rnd [3];
    logic signed [A_W:0]   n_sh [3];
    logic signed [DW-1:0]  n_o [3];
    logic signed [DW-1:0]  r_o [3];
    logic                  r_o_dg;

    assign w_adv      = !(r_vld[LAST] && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_thr[0][0] <= i_thrust_tangential;
            r_thr[0][1] <= i_thrust_normal;
            r_thr[0][2] <= i_thrust_crosstrack;
            for (int k = 1; k <= ST_N; k++) begin
                r_thr[k] <= r_thr[k-1];
            end
            r_a_r[0] <= i_position_x;
            r_a_r[1] <= i_position_y;
            r_a_r[2] <= i_position_z;
            r_a_v[0] <= i_velocity_x;
            r_a_v[1] <= i_velocity_y;
            r_a_v[2] <= i_velocity_z;
        end
    end

    if (DW <= PS_W) begin : g_ext
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_b_r[i] = PS_W'(r_a_r[i]);
                n_b_v[i] = PS_W'(r_a_v[i]);
            end
        end
    end else begin : g_shift
        localparam int SH_MAX = DW - PS_W;
        localparam int SH_W   = $clog2(SH_MAX + 1);
        logic [SH_W-1:0] w_sr;
        logic [SH_W-1:0] w_sv;

        always_comb begin
            logic                 ok_r;
            logic                 ok_v;
            logic signed [DW-1:0] hi_r;
            logic signed [DW-1:0] hi_v;
            w_sr = SH_W'(SH_MAX);
            w_sv = SH_W'(SH_MAX);
            for (int s = SH_MAX; s >= 0; s--) begin
                ok_r = 1'b1;
                ok_v = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    hi_r = r_a_r[i] >>> (s + PS_W - 1);
                    hi_v = r_a_v[i] >>> (s + PS_W - 1);
                    if (!(hi_r == '0 || hi_r == '1)) begin
                        ok_r = 1'b0;
                    end
                    if (!(hi_v == '0 || hi_v == '1)) begin
                        ok_v = 1'b0;
                    end
                end
                if (ok_r) begin
                    w_sr = SH_W'(s);
                end
                if (ok_v) begin
                    w_sv = SH_W'(s);
                end
            end
            for (int i = 0; i < 3; i++) begin
                n_b_r[i] = PS_W'(r_a_r[i] >>> w_sr);
                n_b_v[i] = PS_W'(r_a_v[i] >>> w_sv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_r <= n_b_r;
            r_b_v <= n_b_v;
            r_c_p[0] <= PRD_W'(r_b_r[1]) * PRD_W'(r_b_v[2]);
            r_c_p[1] <= PRD_W'(r_b_r[2]) * PRD_W'(r_b_v[1]);
            r_c_p[2] <= PRD_W'(r_b_r[2]) * PRD_W'(r_b_v[0]);
            r_c_p[3] <= PRD_W'(r_b_r[0]) * PRD_W'(r_b_v[2]);
            r_c_p[4] <= PRD_W'(r_b_r[0]) * PRD_W'(r_b_v[1]);
            r_c_p[5] <= PRD_W'(r_b_r[1]) * PRD_W'(r_b_v[0]);
            r_c_v    <= r_b_v;
            for (int i = 0; i < 3; i++) begin
                r_d_c[i] <= CX_W'(r_c_p[2*i]) - CX_W'(r_c_p[2*i+1]);
                r_d_v[i] <= CX_W'(r_c_v[i]);
            end
        end
    end

    tnwc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_w (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (r_d_c),
        .o_u    (w_w),
        .o_zero (w_wzero)
    );

    tnwc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_t (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (r_d_v),
        .o_u    (w_t),
        .o_zero ()
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dt[ST_U+1] <= w_t;
            r_dw[ST_U+1] <= w_w;
            r_dg[ST_U+1] <= w_wzero;
            for (int k = ST_U + 2; k <= ST_N; k++) begin
                r_dt[k] <= r_dt[k-1];
                r_dw[k] <= r_dw[k-1];
            end
            for (int k = ST_U + 2; k <= ST_H; k++) begin
                r_dg[k] <= r_dg[k-1];
            end
            r_e_p[0] <= (2*U_W)'(w_w[1]) * (2*U_W)'(w_t[2]);
            r_e_p[1] <= (2*U_W)'(w_w[2]) * (2*U_W)'(w_t[1]);
            r_e_p[2] <= (2*U_W)'(w_w[2]) * (2*U_W)'(w_t[0]);
            r_e_p[3] <= (2*U_W)'(w_w[0]) * (2*U_W)'(w_t[2]);
            r_e_p[4] <= (2*U_W)'(w_w[0]) * (2*U_W)'(w_t[1]);
            r_e_p[5] <= (2*U_W)'(w_w[1]) * (2*U_W)'(w_t[0]);
            for (int i = 0; i < 3; i++) begin
                r_f_n[i] <= CX_W'(r_e_p[2*i]) - CX_W'(r_e_p[2*i+1]);
            end
        end
    end

    tnwc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_n (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_a    (r_f_n),
        .o_u    (w_n),
        .o_zero ()
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = (A_W+1)'(r_h_acc[i]) + RND;
            n_sh[i]  = n_rnd[i] >>> FRAC_BITS;
            if (r_dg[ST_H]) begin
                n_o[i] = '0;
            end else if (n_sh[i] > SAT_MAX) begin
                n_o[i] = SAT_MAX[DW-1:0];
            end else if (n_sh[i] < SAT_MIN) begin
                n_o[i] = SAT_MIN[DW-1:0];
            end else begin
                n_o[i] = n_sh[i][DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_g_p[i][0] <= P_W'(r_dt[ST_N][i]) * P_W'(r_thr[ST_N][0]);
                r_g_p[i][1] <= P_W'(w_n[i]) * P_W'(r_thr[ST_N][1]);
                r_g_p[i][2] <= P_W'(r_dw[ST_N][i]) * P_W'(r_thr[ST_N][2]);
                r_h_acc[i]  <= A_W'(r_g_p[i][0]) + A_W'(r_g_p[i][1]) + A_W'(r_g_p[i][2]);
            end
            r_o    <= n_o;
            r_o_dg <= r_dg[ST_H];
        end
    end

    assign o_out_valid  = r_vld[LAST];
    assign o_thrust_x   = r_o[0];
    assign o_thrust_y   = r_o[1];
    assign o_thrust_z   = r_o[2];
    assign o_degenerate = r_o_dg;

    a_degenerate_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_thrust_x == '0 && o_thrust_y == '0
                                           && o_thrust_z == '0))
        else $error("Degenerate result carries a nonzero thrust.");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_thrust_x)
                                          && $stable(o_degenerate)))
        else $error("A stalled result was lost or changed.");

    a_valid_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall) |=> (r_vld[1] == $past(r_vld[0])))
        else $error("Valid bit did not follow its transaction.");

endmodule
